// ===== sv/wlan_frame_airtime_calc_unit_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the frame airtime unit
// ----------------------------------------------------------------------------
`ifndef WLAN_FRAME_AIRTIME_CALC_UNIT_MACROS_SVH
`define WLAN_FRAME_AIRTIME_CALC_UNIT_MACROS_SVH

// same-cycle implication
`define WFAC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("airtime unit assertion failed");

// next-cycle implication
`define WFAC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("airtime unit assertion failed");

`endif

// ===== sv/wfac_pkg.sv =====
// ----------------------------------------------------------------------------
// wfac_pkg
// types and constants shared by the frame airtime unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wfac_pkg;

   localparam logic [2:0] KIND_CCK     = 3'd0;
   localparam logic [2:0] KIND_OFDM    = 3'd1;
   localparam logic [2:0] KIND_HALF    = 3'd2;
   localparam logic [2:0] KIND_QUARTER = 3'd3;
   localparam logic [2:0] KIND_TURBO   = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ZERO_RATE = 2'd1;
   localparam logic [1:0] ST_ZERO_BPS  = 2'd2;
   localparam logic [1:0] ST_BAD_PHY   = 2'd3;

   localparam int NUM_W   = 27;   // bytes * 8000 fits
   localparam int DEN_W   = 17;
   localparam int BITS_PER_STAGE = 3;
   localparam int DIV_STAGES = NUM_W / BITS_PER_STAGE;
   localparam int PROD_W  = 45;   // 22-bit bit rate times 23-bit reciprocal
   localparam int BPS_W   = 13;

   // ceil(2^32 / 1000), exact for products below 2^22
   localparam logic [22:0] RECIP_1000 = 23'd4294968;

   localparam logic [7:0] BASE_CCK_LONG  = 8'd202;
   localparam logic [7:0] BASE_CCK_SHORT = 8'd106;
   localparam logic [7:0] BASE_OFDM      = 8'd36;
   localparam logic [7:0] BASE_HALF      = 8'd72;
   localparam logic [7:0] BASE_QUARTER   = 8'd144;
   localparam logic [7:0] BASE_TURBO     = 8'd22;

   localparam logic [15:0] DUR_MAX = 16'hFFFF;

   typedef struct packed {
      logic [13:0] frame_bytes;
      logic [16:0] rate_kbps;
      logic [2:0]  phy_kind;
      logic        want_short_preamble;
      logic        rate_allows_short;
   } req_type;

   typedef struct packed {
      logic [15:0] duration_us;
      logic [1:0]  status;
      logic        saturated;
   } rsp_type;

   typedef struct packed {
      logic [1:0] status;
      logic       cck;
      logic [2:0] sym_sh;
      logic [7:0] base;
   } meta_type;

   typedef struct packed {
      meta_type           meta;
      logic [NUM_W-1:0]   num;
      logic [DEN_W-1:0]   rem;
      logic [NUM_W-1:0]   quo;
      logic [DEN_W-1:0]   den;
   } pipe_type;

endpackage

`default_nettype wire

// ===== sv/wfac_front.sv =====
// ----------------------------------------------------------------------------
// wfac_front
// two stages: bit rate reciprocal product, then divider operand set-up
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wfac_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              valid_in,
   input  wire wfac_pkg::req_type req_in,
   output logic                   valid_out,
   output wfac_pkg::pipe_type     pipe_out
);

   logic                             v1_ff;
   wfac_pkg::req_type                r1_ff;
   logic [wfac_pkg::PROD_W-1:0]      prod1_ff, prod1_in;
   logic [17:0]                      kbps_eff;
   logic [21:0]                      scaled;
   logic [2:0]                       sh1;

   logic                             v2_ff;
   wfac_pkg::pipe_type               p2_ff, p2_in;
   logic [wfac_pkg::BPS_W-1:0]       bps;
   logic [16:0]                      bits;

   // stage 1
   always_comb begin
      unique case (req_in.phy_kind)
         wfac_pkg::KIND_HALF:    sh1 = 3'd3;
         wfac_pkg::KIND_QUARTER: sh1 = 3'd4;
         default:                sh1 = 3'd2;
      endcase
      if (req_in.phy_kind == wfac_pkg::KIND_TURBO) begin
         kbps_eff = {req_in.rate_kbps, 1'b0};
      end else begin
         kbps_eff = {1'b0, req_in.rate_kbps};
      end
      scaled   = 22'({kbps_eff, 4'b0} >> (3'd4 - sh1));
      prod1_in = wfac_pkg::PROD_W'(scaled) * wfac_pkg::PROD_W'(wfac_pkg::RECIP_1000);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff    <= req_in;
         prod1_ff <= prod1_in;
      end
   end

   // stage 2
   always_comb begin
      bps  = prod1_ff[wfac_pkg::PROD_W-1:32];
      bits = {r1_ff.frame_bytes, 3'b0};
      p2_in = '0;
      p2_in.rem = '0;
      p2_in.quo = '0;
      if (r1_ff.phy_kind == wfac_pkg::KIND_CCK) begin
         p2_in.meta.cck    = 1'b1;
         p2_in.meta.sym_sh = 3'd0;
         p2_in.meta.base   = (r1_ff.want_short_preamble && r1_ff.rate_allows_short)
                             ? wfac_pkg::BASE_CCK_SHORT : wfac_pkg::BASE_CCK_LONG;
         p2_in.num = wfac_pkg::NUM_W'(r1_ff.frame_bytes) * wfac_pkg::NUM_W'(8000);
         p2_in.den = r1_ff.rate_kbps;
      end else begin
         p2_in.meta.cck = 1'b0;
         p2_in.num = wfac_pkg::NUM_W'(bits) + wfac_pkg::NUM_W'(22)
                     + wfac_pkg::NUM_W'(bps) - wfac_pkg::NUM_W'(1);
         p2_in.den = wfac_pkg::DEN_W'(bps);
         unique case (r1_ff.phy_kind)
            wfac_pkg::KIND_HALF: begin
               p2_in.meta.sym_sh = 3'd3;
               p2_in.meta.base   = wfac_pkg::BASE_HALF;
            end
            wfac_pkg::KIND_QUARTER: begin
               p2_in.meta.sym_sh = 3'd4;
               p2_in.meta.base   = wfac_pkg::BASE_QUARTER;
            end
            wfac_pkg::KIND_TURBO: begin
               p2_in.meta.sym_sh = 3'd2;
               p2_in.meta.base   = wfac_pkg::BASE_TURBO;
            end
            default: begin
               p2_in.meta.sym_sh = 3'd2;
               p2_in.meta.base   = wfac_pkg::BASE_OFDM;
            end
         endcase
      end
      priority if (r1_ff.rate_kbps == '0) begin
         p2_in.meta.status = wfac_pkg::ST_ZERO_RATE;
      end else if (r1_ff.phy_kind > wfac_pkg::KIND_TURBO) begin
         p2_in.meta.status = wfac_pkg::ST_BAD_PHY;
      end else if (r1_ff.phy_kind != wfac_pkg::KIND_CCK && bps == '0) begin
         p2_in.meta.status = wfac_pkg::ST_ZERO_BPS;
      end else begin
         p2_in.meta.status = wfac_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_ff <= p2_in;
      end
   end

   assign valid_out = v2_ff;
   assign pipe_out  = p2_ff;

endmodule

`default_nettype wire

// ===== sv/wfac_div_stage.sv =====
// ----------------------------------------------------------------------------
// wfac_div_stage
// one restoring divider stage, three quotient bits per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wfac_div_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               valid_in,
   input  wire wfac_pkg::pipe_type pipe_in,
   output logic                    valid_out,
   output wfac_pkg::pipe_type      pipe_out
);

   logic               v_ff;
   wfac_pkg::pipe_type p_ff, p_in;
   logic [wfac_pkg::DEN_W:0] trial;
   logic                     ge;

   always_comb begin
      trial = '0;
      ge    = 1'b0;
      p_in  = pipe_in;
      for (int i = 0; i < wfac_pkg::BITS_PER_STAGE; i++) begin
         trial    = {p_in.rem, p_in.num[wfac_pkg::NUM_W-1]};
         p_in.num = {p_in.num[wfac_pkg::NUM_W-2:0], 1'b0};
         ge       = (trial >= {1'b0, p_in.den});
         if (ge) begin
            trial = trial - {1'b0, p_in.den};
         end
         p_in.rem = trial[wfac_pkg::DEN_W-1:0];
         p_in.quo = {p_in.quo[wfac_pkg::NUM_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign valid_out = v_ff;
   assign pipe_out  = p_ff;

endmodule

`default_nettype wire

// ===== sv/wfac_back.sv =====
// ----------------------------------------------------------------------------
// wfac_back
// final add, saturation and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wfac_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               valid_in,
   input  wire wfac_pkg::pipe_type pipe_in,
   output logic                    valid_out,
   output wfac_pkg::rsp_type       rsp_out
);

   logic              v_ff;
   wfac_pkg::rsp_type r_ff, r_in;
   logic [31:0]       total;

   always_comb begin
      if (pipe_in.meta.cck) begin
         total = 32'(pipe_in.meta.base) + 32'(pipe_in.quo);
      end else begin
         total = 32'(pipe_in.meta.base) + (32'(pipe_in.quo) << pipe_in.meta.sym_sh);
      end
      r_in.status = pipe_in.meta.status;
      if (pipe_in.meta.status != wfac_pkg::ST_OK) begin
         r_in.duration_us = '0;
         r_in.saturated   = 1'b0;
      end else if (total > 32'(wfac_pkg::DUR_MAX)) begin
         r_in.duration_us = wfac_pkg::DUR_MAX;
         r_in.saturated   = 1'b1;
      end else begin
         r_in.duration_us = total[15:0];
         r_in.saturated   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in;
      end
   end

   assign valid_out = v_ff;
   assign rsp_out   = r_ff;

endmodule

`default_nettype wire

// ===== sv/wlan_frame_airtime_calc_unit.sv =====
// ----------------------------------------------------------------------------
// wlan_frame_airtime_calc_unit
// 802.11 frame air time in microseconds including sifs, pipelined
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | word
//  req      | in        | req_valid/req_stall | frame length, rate, phy, preamble
//  rsp      | out       | rsp_valid/rsp_stall | duration, status, saturated
//
//  one word accepted per cycle while req_stall is low; 2 set-up stages,
//  9 divider stages of 3 quotient bits each, 1 result stage
//  the 27-bit restoring divider pipeline sets the depth
//  synchronous active-high reset clears all valid bits
//  whole pipeline holds while a result waits under rsp_stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wlan_frame_airtime_calc_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire wfac_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output wfac_pkg::rsp_type      rsp_word
);

   // pipeline moves unless a finished result is being held
   logic en;

   // stage chain: index 0 is the front output, each divider stage adds one
   logic               v_chain [wfac_pkg::DIV_STAGES+1];
   wfac_pkg::pipe_type p_chain [wfac_pkg::DIV_STAGES+1];

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // reciprocal multiply for bits per symbol, then divider operands
   wfac_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (req_valid),
      .req_in    (req_word),
      .valid_out (v_chain[0]),
      .pipe_out  (p_chain[0])
   );

   // cck: bytes*8000 / kbps; ofdm: ceil((bits+22) / bps)
   for (genvar g = 0; g < wfac_pkg::DIV_STAGES; g++) begin : g_div
      wfac_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .valid_in  (v_chain[g]),
         .pipe_in   (p_chain[g]),
         .valid_out (v_chain[g+1]),
         .pipe_out  (p_chain[g+1])
      );
   end

   // preamble and sifs added, result clamped to 16 bits
   wfac_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (v_chain[wfac_pkg::DIV_STAGES]),
      .pipe_in   (p_chain[wfac_pkg::DIV_STAGES]),
      .valid_out (rsp_valid),
      .rsp_out   (rsp_word)
   );

endmodule

`default_nettype wire

// ===== sv/wfac_checker.sv =====
// ----------------------------------------------------------------------------
// wfac_checker
// port-level checks on the frame airtime unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "wlan_frame_airtime_calc_unit_macros.svh"

module wfac_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire wfac_pkg::req_type req_word,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire wfac_pkg::rsp_type rsp_word
);

   `WFAC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))
   `WFAC_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && rsp_word.status != wfac_pkg::ST_OK, rsp_word.duration_us == 16'd0 && !rsp_word.saturated)
   `WFAC_ASSERT_IMP(a_sat_max, clock, reset, rsp_valid && rsp_word.saturated, rsp_word.duration_us == wfac_pkg::DUR_MAX)
   `WFAC_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

endmodule

bind wlan_frame_airtime_calc_unit wfac_checker u_wfac_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

`default_nettype wire
